FILE: hw/rtl/cic_pkg.sv
// Types and constants for the cascaded interrupt controller pair.
// Depends on nothing; imported by cascaded_interrupt_controller.
package cic_pkg;

   localparam int NUM_CHIPS  = 2;
   localparam int NUM_LEVELS = 8;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_ACK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PHASE_OPER = 2'd0,
      PHASE_ICW2 = 2'd1,
      PHASE_ICW3 = 2'd2,
      PHASE_ICW4 = 2'd3
   } phase_type;

   localparam logic       PORT_CMD       = 1'b0;
   localparam logic       CHIP_MASTER    = 1'b0;
   localparam logic       CHIP_SLAVE     = 1'b1;
   localparam logic [2:0] CASCADE_LEVEL  = 3'd2;
   localparam logic [2:0] SPURIOUS_LEVEL = 3'd7;
   localparam logic [2:0] OCW2_NS_EOI    = 3'b001;
   localparam int         ICW1_BIT       = 4;
   localparam int         OCW3_BIT       = 3;
   localparam int         OCW3_RR_BIT    = 1;
   localparam int         OCW3_RIS_BIT   = 0;
   localparam logic [7:0] CASCADE_MASK   = 8'h04;
   localparam logic [7:0] MASTER_LINES   = 8'hfb;

   typedef struct packed {
      logic [7:0] request;
      logic [7:0] in_service;
      logic [7:0] mask;
      logic [4:0] vector_base;
      phase_type  phase;
      logic       icw4_expected;
      logic       single_mode;
      logic       read_isr_sel;
      logic [7:0] prev_lines;
   } chip_state_type;

   typedef struct packed {
      logic       found;
      logic [2:0] num;
   } level_type;

endpackage

FILE: hw/rtl/cascaded_interrupt_controller.sv
// Master and slave interrupt controllers, slave cascaded on master input 2.
// A request beat is held in the request register; its result beat is presented
// from the result register. Throughput: one beat per cycle unless rsp_stall holds
// a result; each beat is decoded and applied to the chip state between the two registers.
// Reset (synchronous) clears both chips to operating phase with all registers
// at zero and empties the request and result registers.
module cascaded_interrupt_controller
   import cic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic        req_chip_sel,
   input  logic        req_port,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_irq_lines,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_int_pending,
   output logic [7:0]  rsp_vector,
   output logic        rsp_vector_valid,
   output logic        rsp_spurious
);

   // Request register
   logic        in_valid_ff;
   op_type      op_ff;
   logic        chip_sel_ff;
   logic        port_ff;
   logic [7:0]  data_ff;
   logic [15:0] lines_ff;

   // Chip state
   chip_state_type chip_ff [NUM_CHIPS];
   chip_state_type chip_in [NUM_CHIPS];

   // Result register
   logic       out_valid_ff;
   logic [7:0] read_data_ff, read_data_in;
   logic       pending_ff, pending_in;
   logic [7:0] vector_ff, vector_in;
   logic       vector_valid_ff, vector_valid_in;
   logic       spurious_ff, spurious_in;

   logic item_go;
   logic req_take;

   // Highest priority eligible level; an in-service level blocks itself and below.
   function automatic level_type best_level(input chip_state_type s);
      level_type  r;
      logic       done;
      logic [7:0] req;
      r    = '0;
      done = 1'b0;
      req  = s.request & ~s.mask;
      for (int n = 0; n < NUM_LEVELS; n++) begin
         if (!done) begin
            if (s.in_service[n]) begin
               done = 1'b1;
            end else if (req[n]) begin
               done    = 1'b1;
               r.found = 1'b1;
               r.num   = 3'(n);
            end
         end
      end
      return r;
   endfunction

   function automatic chip_state_type grant(input chip_state_type s, input logic [2:0] n);
      chip_state_type r;
      r            = s;
      r.request    = s.request & ~(8'b1 << n);
      r.in_service = s.in_service | (8'b1 << n);
      return r;
   endfunction

   function automatic chip_state_type write_port(input chip_state_type s, input logic port,
                                                 input logic [7:0] d);
      chip_state_type r;
      r = s;
      if (port == PORT_CMD) begin
         if (d[ICW1_BIT]) begin
            r.phase         = PHASE_ICW2;
            r.icw4_expected = d[0];
            r.single_mode   = d[1];
            r.request       = '0;
            r.in_service    = '0;
            r.mask          = '0;
            r.read_isr_sel  = 1'b0;
         end else if (d[OCW3_BIT]) begin
            if (d[OCW3_RR_BIT]) begin
               r.read_isr_sel = d[OCW3_RIS_BIT];
            end
         end else if (d[7:5] == OCW2_NS_EOI) begin
            // Clearing the lowest set bit drops the highest priority level.
            r.in_service = s.in_service & (s.in_service - 8'd1);
         end
      end else begin
         unique case (s.phase)
            PHASE_ICW2: begin
               r.vector_base = d[7:3];
               if (s.single_mode) begin
                  r.phase = s.icw4_expected ? PHASE_ICW4 : PHASE_OPER;
               end else begin
                  r.phase = PHASE_ICW3;
               end
            end
            PHASE_ICW3: r.phase = s.icw4_expected ? PHASE_ICW4 : PHASE_OPER;
            PHASE_ICW4: r.phase = PHASE_OPER;
            PHASE_OPER: r.mask  = d;
         endcase
      end
      return r;
   endfunction

   assign item_go   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !item_go;
   assign req_take  = req_valid && !req_stall;

   // Next chip state
   always_comb begin
      level_type  m_lvl;
      level_type  s_lvl;
      level_type  s_out;
      logic [7:0] lo;
      logic [7:0] hi;
      chip_in[CHIP_MASTER] = chip_ff[CHIP_MASTER];
      chip_in[CHIP_SLAVE]  = chip_ff[CHIP_SLAVE];
      m_lvl = best_level(chip_ff[CHIP_MASTER]);
      s_lvl = best_level(chip_ff[CHIP_SLAVE]);
      lo    = lines_ff[7:0] & MASTER_LINES;
      hi    = lines_ff[15:8];
      if (item_go) begin
         unique case (op_ff)
            OP_READ: begin
            end
            OP_WRITE: begin
               chip_in[chip_sel_ff] = write_port(chip_ff[chip_sel_ff], port_ff, data_ff);
            end
            OP_SAMPLE: begin
               chip_in[CHIP_MASTER].request = chip_ff[CHIP_MASTER].request
                                            | (lo & ~chip_ff[CHIP_MASTER].prev_lines);
               chip_in[CHIP_MASTER].prev_lines = (chip_ff[CHIP_MASTER].prev_lines
                                                 & CASCADE_MASK) | lo;
               chip_in[CHIP_SLAVE].request = chip_ff[CHIP_SLAVE].request
                                           | (hi & ~chip_ff[CHIP_SLAVE].prev_lines);
               chip_in[CHIP_SLAVE].prev_lines = hi;
            end
            OP_ACK: begin
               if (m_lvl.found) begin
                  chip_in[CHIP_MASTER] = grant(chip_ff[CHIP_MASTER], m_lvl.num);
                  if (m_lvl.num == CASCADE_LEVEL && !chip_ff[CHIP_MASTER].single_mode
                      && s_lvl.found) begin
                     chip_in[CHIP_SLAVE] = grant(chip_ff[CHIP_SLAVE], s_lvl.num);
                  end
               end
            end
         endcase
      end
      // The slave output drives master input 2 through its own edge detector.
      s_out = best_level(chip_in[CHIP_SLAVE]);
      if (s_out.found) begin
         if (!chip_in[CHIP_MASTER].prev_lines[CASCADE_LEVEL]) begin
            chip_in[CHIP_MASTER].request[CASCADE_LEVEL] = 1'b1;
         end
         chip_in[CHIP_MASTER].prev_lines[CASCADE_LEVEL] = 1'b1;
      end else begin
         chip_in[CHIP_MASTER].prev_lines[CASCADE_LEVEL] = 1'b0;
      end
   end

   // Result fields
   always_comb begin
      level_type      m_lvl;
      level_type      s_lvl;
      level_type      m_out;
      chip_state_type sel;
      m_lvl           = best_level(chip_ff[CHIP_MASTER]);
      s_lvl           = best_level(chip_ff[CHIP_SLAVE]);
      m_out           = best_level(chip_in[CHIP_MASTER]);
      sel             = chip_ff[chip_sel_ff];
      read_data_in    = '0;
      vector_in       = '0;
      vector_valid_in = 1'b0;
      spurious_in     = 1'b0;
      pending_in      = m_out.found;
      unique case (op_ff)
         OP_READ: begin
            if (port_ff == PORT_CMD) begin
               read_data_in = sel.read_isr_sel ? sel.in_service : sel.request;
            end else begin
               read_data_in = sel.mask;
            end
         end
         OP_WRITE, OP_SAMPLE: begin
         end
         OP_ACK: begin
            vector_valid_in = 1'b1;
            if (!m_lvl.found) begin
               vector_in   = {chip_ff[CHIP_MASTER].vector_base, SPURIOUS_LEVEL};
               spurious_in = 1'b1;
            end else if (m_lvl.num == CASCADE_LEVEL && !chip_ff[CHIP_MASTER].single_mode) begin
               if (s_lvl.found) begin
                  vector_in = {chip_ff[CHIP_SLAVE].vector_base, s_lvl.num};
               end else begin
                  vector_in   = {chip_ff[CHIP_SLAVE].vector_base, SPURIOUS_LEVEL};
                  spurious_in = 1'b1;
               end
            end else begin
               vector_in = {chip_ff[CHIP_MASTER].vector_base, m_lvl.num};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         chip_ff[CHIP_MASTER] <= '0;
         chip_ff[CHIP_SLAVE]  <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (item_go) begin
            in_valid_ff <= 1'b0;
         end
         if (item_go) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         chip_ff[CHIP_MASTER] <= chip_in[CHIP_MASTER];
         chip_ff[CHIP_SLAVE]  <= chip_in[CHIP_SLAVE];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= op_type'(req_op);
         chip_sel_ff <= req_chip_sel;
         port_ff     <= req_port;
         data_ff     <= req_write_data;
         lines_ff    <= req_irq_lines;
      end
      if (item_go) begin
         read_data_ff    <= read_data_in;
         pending_ff      <= pending_in;
         vector_ff       <= vector_in;
         vector_valid_ff <= vector_valid_in;
         spurious_ff     <= spurious_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = read_data_ff;
   assign rsp_int_pending  = pending_ff;
   assign rsp_vector       = vector_ff;
   assign rsp_vector_valid = vector_valid_ff;
   assign rsp_spurious     = spurious_ff;

endmodule
